### rtl/core/fmipc_pkg.sv
// Shared types and constants of the first-match IP prefix classifier.
`timescale 1ns / 1ps

package fmipc_pkg;

	// Field widths fixed by the request format
	localparam int ADDR_W     = 32;
	localparam int MATCH_W    = 16;
	localparam int ID_W       = 8;
	localparam int APP_W      = 8;
	localparam int SLOT_W     = 6;
	localparam int ACT_PORT_W = 32;
	localparam int COUNT_W    = 32;

	// Configuration port
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_HTTP_APP_TYPE  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_ACTION = 8'd1;
	localparam logic [APP_W-1:0]       HTTP_APP_RESET     = 8'd1;

	// Operation codes
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_WRITE    = 1'b1;

	// Result constants
	localparam logic [MATCH_W-1:0] CLEAR_BIT0 = 16'hfffe;
	localparam logic [ID_W-1:0]    MISS_ID    = 8'd255;

	// Match key of one rule
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] net;
		logic [ADDR_W-1:0] mask;
	} rule_key_t;

endpackage

### rtl/core/fmipc_rule_mem.sv
// Rule table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module fmipc_rule_mem #(
	parameter int DEPTH = 64,
	parameter int IW    = 6,
	parameter int DW    = 32
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IW-1:0]             waddr,
	input  fmipc_pkg::rule_key_t      wkey,
	input  logic [fmipc_pkg::ID_W-1:0] wid,
	input  logic [DW-1:0]             wact,
	input  logic                      re,
	input  logic [IW-1:0]             raddr,
	output fmipc_pkg::rule_key_t      rkey,
	output logic [fmipc_pkg::ID_W-1:0] rid,
	output logic [DW-1:0]             ract
);
	import fmipc_pkg::*;

	rule_key_t       key_mem [DEPTH];
	logic [ID_W-1:0] id_mem  [DEPTH];
	logic [DW-1:0]   act_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			id_mem[waddr]  <= wid;
			act_mem[waddr] <= wact;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rkey <= key_mem[raddr];
			rid  <= id_mem[raddr];
			ract <= act_mem[raddr];
		end
	end

endmodule

### rtl/core/fmipc_match_unit.sv
// Shared masked comparator: source address against one rule entry.
`timescale 1ns / 1ps

module fmipc_match_unit (
	input  logic [fmipc_pkg::ADDR_W-1:0] src_ip,
	input  fmipc_pkg::rule_key_t         key,
	output logic                         match
);
	import fmipc_pkg::*;

	// entry must be effective and agree on every masked bit
	assign match = key.valid && ((src_ip & key.mask) == (key.net & key.mask));

endmodule

### rtl/core/first_match_ip_prefix_classifier.sv
// Top level of the first-match IP prefix classifier: sequencer, counters, result register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   operation, app_code, src_ip, match_in, entry_*
//   out      output     out_valid / out_stall examined, hit, match_out, hit_id, action_out, counts
//   cfg      input      cfg_wen               cfg_index, cfg_wdata
//
// A classified packet is scanned: the scan reads one table entry per cycle through
// the single read port into the shared comparator, and stops at the first hit or
// at the last entry. After reset a clearing pass over all RULE_COUNT entries
// resets the valid marks; requests wait meanwhile, configuration writes are taken.
// A new request is taken only once the result register is free or being drained.
`timescale 1ns / 1ps

module first_match_ip_prefix_classifier #(
	parameter int RULE_COUNT   = 64,
	parameter int ACTION_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [fmipc_pkg::APP_W-1:0]        app_code,
	input  logic [fmipc_pkg::ADDR_W-1:0]       src_ip,
	input  logic [fmipc_pkg::MATCH_W-1:0]      match_in,
	input  logic [fmipc_pkg::SLOT_W-1:0]       entry_slot,
	input  logic                               entry_valid,
	input  logic [fmipc_pkg::ADDR_W-1:0]       entry_ip,
	input  logic [fmipc_pkg::ADDR_W-1:0]       entry_mask,
	input  logic [fmipc_pkg::ID_W-1:0]         entry_id,
	input  logic [fmipc_pkg::ACT_PORT_W-1:0]   entry_action,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               examined,
	output logic                               hit,
	output logic [fmipc_pkg::MATCH_W-1:0]      match_out,
	output logic [fmipc_pkg::ID_W-1:0]         hit_id,
	output logic [fmipc_pkg::ACT_PORT_W-1:0]   action_out,
	output logic [fmipc_pkg::COUNT_W-1:0]      total_count,
	output logic [fmipc_pkg::COUNT_W-1:0]      other_count,
	output logic [fmipc_pkg::COUNT_W-1:0]      url_count,
	output logic [fmipc_pkg::COUNT_W-1:0]      miss_count,
	output logic [fmipc_pkg::COUNT_W-1:0]      hit_count,
	// configuration port
	input  logic                               cfg_wen,
	input  logic [fmipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fmipc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import fmipc_pkg::*;

	localparam int IW      = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
	localparam int STORE_W = (ACTION_WIDTH < ACT_PORT_W) ? ACTION_WIDTH : ACT_PORT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(RULE_COUNT - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0]              state_q;
	logic [IW-1:0]           scan_q;
	logic                    issue_q;
	logic                    cmp_vld_s1;
	logic [IW-1:0]           cmp_idx_s1;
	logic [ADDR_W-1:0]       src_q;
	logic [MATCH_W-1:0]      match_q;

	logic [APP_W-1:0]        http_app_type_q;
	logic [CFG_DATA_W-1:0]   default_action_q;

	logic [COUNT_W-1:0]      total_q, other_q, url_q, miss_q, hit_cnt_q;

	logic                    out_valid_q;
	logic                    examined_q, hit_q;
	logic [MATCH_W-1:0]      match_out_q;
	logic [ID_W-1:0]         hit_id_q;
	logic [ACT_PORT_W-1:0]   action_q;

	logic                    accept, pkt_acc, wr_acc, is_http, slot_ok;
	logic                    rule_hit, scan_last, finish;
	logic                    mem_we, mem_re;
	logic [IW-1:0]           mem_waddr;
	rule_key_t               mem_wkey, mem_rkey;
	logic [ID_W-1:0]         mem_rid;
	logic [STORE_W-1:0]      mem_ract;
	logic                    match_w;

	// request handshake and decode
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign pkt_acc   = accept && (operation == OP_CLASSIFY);
	assign wr_acc    = accept && (operation == OP_WRITE);
	assign is_http   = (app_code == http_app_type_q);
	assign slot_ok   = 32'(entry_slot) < RULE_COUNT;

	// scan outcome from the comparator stage
	assign rule_hit  = cmp_vld_s1 && match_w;
	assign scan_last = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
	assign finish    = (state_q == ST_SCAN) && (rule_hit || scan_last);

	// table write port: clearing pass or rule write
	always_comb begin
		mem_we         = (state_q == ST_CLEAR) || (wr_acc && slot_ok);
		mem_waddr      = (state_q == ST_CLEAR) ? scan_q : IW'(entry_slot);
		mem_wkey.valid = (state_q != ST_CLEAR) && entry_valid;
		mem_wkey.net   = entry_ip;
		mem_wkey.mask  = entry_mask;
	end
	assign mem_re = (state_q == ST_SCAN) && issue_q;

	fmipc_rule_mem #(
		.DEPTH (RULE_COUNT),
		.IW    (IW),
		.DW    (STORE_W)
	) u_rule_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wid   (entry_id),
		.wact  (STORE_W'(entry_action)),
		.re    (mem_re),
		.raddr (scan_q),
		.rkey  (mem_rkey),
		.rid   (mem_rid),
		.ract  (mem_ract)
	);

	fmipc_match_unit u_match (
		.src_ip (src_q),
		.key    (mem_rkey),
		.match  (match_w)
	);

	// sequencer, counters, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			scan_q           <= '0;
			issue_q          <= 1'b0;
			cmp_vld_s1       <= 1'b0;
			cmp_idx_s1       <= '0;
			out_valid_q      <= 1'b0;
			http_app_type_q  <= HTTP_APP_RESET;
			default_action_q <= '0;
			total_q          <= '0;
			other_q          <= '0;
			url_q            <= '0;
			miss_q           <= '0;
			hit_cnt_q        <= '0;
		end else begin
			// configuration writes
			if (cfg_wen) begin
				if (cfg_index == REG_HTTP_APP_TYPE) begin
					http_app_type_q <= cfg_wdata[APP_W-1:0];
				end else if (cfg_index == REG_DEFAULT_ACTION) begin
					default_action_q <= cfg_wdata;
				end
			end

			// result register drains first, then may refill
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish || (pkt_acc && !is_http)) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_CLEAR: begin
					if (scan_q == LAST_IDX) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pkt_acc) begin
						total_q <= total_q + 1'b1;
						if (is_http) begin
							url_q   <= url_q + 1'b1;
							scan_q  <= '0;
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							other_q <= other_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					// read issue, one entry per cycle
					cmp_vld_s1 <= issue_q;
					cmp_idx_s1 <= scan_q;
					if (issue_q) begin
						if (scan_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					// first hit or end of table
					if (finish) begin
						issue_q    <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_IDLE;
						if (rule_hit) begin
							hit_cnt_q <= hit_cnt_q + 1'b1;
						end else begin
							miss_q <= miss_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// packet payload held for the scan
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			src_q   <= src_ip;
			match_q <= match_in;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pkt_acc && !is_http) begin
			examined_q  <= 1'b0;
			hit_q       <= 1'b0;
			match_out_q <= match_in;
			hit_id_q    <= '0;
			action_q    <= '0;
		end else if (finish) begin
			examined_q <= 1'b1;
			if (rule_hit) begin
				hit_q       <= 1'b1;
				match_out_q <= match_q | MATCH_W'(1);
				hit_id_q    <= mem_rid;
				action_q    <= ACT_PORT_W'(mem_ract);
			end else begin
				hit_q       <= 1'b0;
				match_out_q <= match_q & CLEAR_BIT0;
				hit_id_q    <= MISS_ID;
				action_q    <= ACT_PORT_W'(STORE_W'(default_action_q));
			end
		end
	end

	// outputs; counters hold still while a result waits
	assign out_valid   = out_valid_q;
	assign examined    = examined_q;
	assign hit         = hit_q;
	assign match_out   = match_out_q;
	assign hit_id      = hit_id_q;
	assign action_out  = action_q;
	assign total_count = total_q;
	assign other_count = other_q;
	assign url_count   = url_q;
	assign miss_count  = miss_q;
	assign hit_count   = hit_cnt_q;

endmodule

### verif/first_match_ip_prefix_classifier_tb.sv
// Self-checking testbench of the first-match IP prefix classifier.
`timescale 1ns / 1ps

module first_match_ip_prefix_classifier_tb;
	import fmipc_pkg::*;

	localparam int RULE_COUNT   = 64;
	localparam int ACTION_WIDTH = 32;
	// worst scan plus result hand-off, with margin
	localparam int DRAIN_CYCLES = RULE_COUNT + 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 330;
	// an index that maps to no register
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

	// One request as it goes onto the input channel
	typedef struct packed {
		logic                  op;
		logic [APP_W-1:0]      app;
		logic [ADDR_W-1:0]     src;
		logic [MATCH_W-1:0]    match_word;
		logic [SLOT_W-1:0]     slot;
		logic                  ent_valid;
		logic [ADDR_W-1:0]     net;
		logic [ADDR_W-1:0]     mask;
		logic [ID_W-1:0]       ident;
		logic [ACT_PORT_W-1:0] action;
	} request_t;

	// One classification verdict as it leaves the result channel
	typedef struct packed {
		logic                  examined;
		logic                  hit;
		logic [MATCH_W-1:0]    match_word;
		logic [ID_W-1:0]       ident;
		logic [ACT_PORT_W-1:0] action;
		logic [COUNT_W-1:0]    total;
		logic [COUNT_W-1:0]    other;
		logic [COUNT_W-1:0]    url;
		logic [COUNT_W-1:0]    miss;
		logic [COUNT_W-1:0]    hits;
	} verdict_t;

	typedef struct {
		bit                    valid;
		logic [ADDR_W-1:0]     net;
		logic [ADDR_W-1:0]     mask;
		logic [ID_W-1:0]       ident;
		logic [ACT_PORT_W-1:0] action;
	} rule_t;

	// DUT ports
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   operation = OP_CLASSIFY;
	logic [APP_W-1:0]       app_code = '0;
	logic [ADDR_W-1:0]      src_ip = '0;
	logic [MATCH_W-1:0]     match_in = '0;
	logic [SLOT_W-1:0]      entry_slot = '0;
	logic                   entry_valid = 1'b0;
	logic [ADDR_W-1:0]      entry_ip = '0;
	logic [ADDR_W-1:0]      entry_mask = '0;
	logic [ID_W-1:0]        entry_id = '0;
	logic [ACT_PORT_W-1:0]  entry_action = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   examined;
	logic                   hit;
	logic [MATCH_W-1:0]     match_out;
	logic [ID_W-1:0]        hit_id;
	logic [ACT_PORT_W-1:0]  action_out;
	logic [COUNT_W-1:0]     total_count;
	logic [COUNT_W-1:0]     other_count;
	logic [COUNT_W-1:0]     url_count;
	logic [COUNT_W-1:0]     miss_count;
	logic [COUNT_W-1:0]     hit_count;
	logic                   cfg_wen = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Predictor state: registers, rule table, packet counters
	logic [APP_W-1:0]       http_type = HTTP_APP_RESET;
	logic [ACT_PORT_W-1:0]  miss_action = '0;
	rule_t                  rule_table [RULE_COUNT];
	logic [COUNT_W-1:0]     pkt_total = '0;
	logic [COUNT_W-1:0]     pkt_other = '0;
	logic [COUNT_W-1:0]     pkt_url = '0;
	logic [COUNT_W-1:0]     pkt_miss = '0;
	logic [COUNT_W-1:0]     pkt_hit = '0;
	verdict_t               pending_verdicts [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int rule_writes = 0;
	int reg_writes = 0;
	int verdicts_seen = 0;
	int cycle_count = 0;

	first_match_ip_prefix_classifier #(
		.RULE_COUNT  (RULE_COUNT),
		.ACTION_WIDTH(ACTION_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.app_code    (app_code),
		.src_ip      (src_ip),
		.match_in    (match_in),
		.entry_slot  (entry_slot),
		.entry_valid (entry_valid),
		.entry_ip    (entry_ip),
		.entry_mask  (entry_mask),
		.entry_id    (entry_id),
		.entry_action(entry_action),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.examined    (examined),
		.hit         (hit),
		.match_out   (match_out),
		.hit_id      (hit_id),
		.action_out  (action_out),
		.total_count (total_count),
		.other_count (other_count),
		.url_count   (url_count),
		.miss_count  (miss_count),
		.hit_count   (hit_count),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	// Clock
	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("FAIL first_match_ip_prefix_classifier");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Result checker: every accepted verdict against the oldest prediction
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				error_count++;
				$display("%0t unexpected verdict: expected none, got hit_id %h action %h",
					$time, hit_id, action_out);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_seen++;
				compare_field("examined", 32'(want.examined), 32'(examined));
				compare_field("hit", 32'(want.hit), 32'(hit));
				compare_field("match_out", 32'(want.match_word), 32'(match_out));
				compare_field("hit_id", 32'(want.ident), 32'(hit_id));
				compare_field("action_out", want.action, action_out);
				compare_field("total_count", want.total, total_count);
				compare_field("other_count", want.other, other_count);
				compare_field("url_count", want.url, url_count);
				compare_field("miss_count", want.miss, miss_count);
				compare_field("hit_count", want.hits, hit_count);
			end
		end
	end

	// First-match lookup of one packet; queues the verdict it must produce
	function automatic void classify_packet(input request_t req);
		verdict_t v;
		int       winner;
		int       k;
		v = '0;
		v.match_word = req.match_word;
		winner = -1;
		pkt_total++;
		if (req.app != http_type) begin
			pkt_other++;
		end else begin
			v.examined = 1'b1;
			pkt_url++;
			for (k = RULE_COUNT - 1; k >= 0; k--) begin
				if (rule_table[k].valid &&
						((req.src & rule_table[k].mask) ==
						(rule_table[k].net & rule_table[k].mask)))
					winner = k;
			end
			if (winner < 0) begin
				pkt_miss++;
				v.match_word = v.match_word & CLEAR_BIT0;
				v.ident = MISS_ID;
				v.action = miss_action;
			end else begin
				pkt_hit++;
				v.hit = 1'b1;
				v.match_word[0] = 1'b1;
				v.ident = rule_table[winner].ident;
				v.action = rule_table[winner].action;
			end
		end
		v.total = pkt_total;
		v.other = pkt_other;
		v.url = pkt_url;
		v.miss = pkt_miss;
		v.hits = pkt_hit;
		pending_verdicts.push_back(v);
	endfunction

	// Update the predictor with one accepted request
	function automatic void apply_request(input request_t req);
		if (req.op == OP_WRITE) begin
			rule_writes++;
			rule_table[req.slot].valid = req.ent_valid;
			rule_table[req.slot].net = req.net;
			rule_table[req.slot].mask = req.mask;
			rule_table[req.slot].ident = req.ident;
			rule_table[req.slot].action = req.action;
		end else begin
			classify_packet(req);
		end
	endfunction

	// Request with every field random; callers then pin what matters
	function automatic request_t noise_request();
		request_t req;
		req.op = OP_CLASSIFY;
		req.app = APP_W'($urandom());
		req.src = $urandom();
		req.match_word = MATCH_W'($urandom());
		req.slot = SLOT_W'($urandom());
		req.ent_valid = 1'($urandom());
		req.net = $urandom();
		req.mask = $urandom();
		req.ident = ID_W'($urandom());
		req.action = $urandom();
		return req;
	endfunction

	function automatic request_t make_packet(input logic [APP_W-1:0] app,
			input logic [ADDR_W-1:0] src, input logic [MATCH_W-1:0] match_word);
		request_t req;
		req = noise_request();
		req.op = OP_CLASSIFY;
		req.app = app;
		req.src = src;
		req.match_word = match_word;
		return req;
	endfunction

	function automatic request_t make_rule(input logic [SLOT_W-1:0] slot, input logic ent_valid,
			input logic [ADDR_W-1:0] net, input logic [ADDR_W-1:0] mask,
			input logic [ID_W-1:0] ident, input logic [ACT_PORT_W-1:0] action);
		request_t req;
		req = noise_request();
		req.op = OP_WRITE;
		req.slot = slot;
		req.ent_valid = ent_valid;
		req.net = net;
		req.mask = mask;
		req.ident = ident;
		req.action = action;
		return req;
	endfunction

	// Mostly prefix masks, some arbitrary ones
	function automatic logic [ADDR_W-1:0] random_mask();
		int len;
		if ($urandom_range(0, 99) < 20)
			return $urandom();
		len = $urandom_range(0, ADDR_W);
		if (len == 0)
			return '0;
		return ~32'h0 << (ADDR_W - len);
	endfunction

	// Random traffic: rule updates, packets aimed at stored rules, other-type noise
	function automatic request_t random_request();
		request_t req;
		int       slot;
		req = noise_request();
		if ($urandom_range(0, 99) < 20) begin
			req.op = OP_WRITE;
			req.ent_valid = ($urandom_range(0, 99) < 85);
			req.mask = random_mask();
			req.ident = ID_W'($urandom_range(0, 255));
		end else begin
			if ($urandom_range(0, 99) < 75)
				req.app = http_type;
			slot = $urandom_range(0, RULE_COUNT - 1);
			if (rule_table[slot].valid && $urandom_range(0, 99) < 60)
				req.src = (rule_table[slot].net & rule_table[slot].mask) |
					(req.src & ~rule_table[slot].mask);
		end
		return req;
	endfunction

	// Send one request; valid stays high afterwards unless the next send idles first
	task automatic send_request(input request_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= req.op;
		app_code <= req.app;
		src_ip <= req.src;
		match_in <= req.match_word;
		entry_slot <= req.slot;
		entry_valid <= req.ent_valid;
		entry_ip <= req.net;
		entry_mask <= req.mask;
		entry_id <= req.ident;
		entry_action <= req.action;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(req);
	endtask

	// Drop valid, wait for every verdict, then let a trailing scan finish
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is idle
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		reg_writes++;
		if (index == REG_HTTP_APP_TYPE)
			http_type = value[APP_W-1:0];
		else if (index == REG_DEFAULT_ACTION)
			miss_action = value[ACT_PORT_W-1:0];
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Reset register values, empty table, non-HTTP packets pass through
	task automatic test_reset_state();
		send_request(make_packet(HTTP_APP_RESET, 32'h0000_0000, 16'hffff));
		send_request(make_packet(8'h00, 32'hffff_ffff, 16'h0000));
		send_request(make_packet(8'hff, 32'h1234_5678, 16'h0001));
		settle_block();
	endtask

	// Lowest valid slot wins; invalid entries never match; id 255 kept as is
	task automatic test_rule_order();
		send_request(make_rule(6'd5, 1'b1, 32'h0a00_0000, 32'hff00_0000, 8'd7, 32'ha5a5_a5a5));
		send_request(make_rule(6'd2, 1'b1, 32'h0a01_0000, 32'hffff_0000, 8'd255,
			32'h5a5a_5a5a));
		send_request(make_rule(6'd63, 1'b1, 32'hffff_ffff, 32'h0000_0000, 8'd254,
			32'hffff_ffff));
		send_request(make_rule(6'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 8'd0, 32'h0));
		send_request(make_packet(HTTP_APP_RESET, 32'h0a01_0203, 16'h0000));
		send_request(make_packet(HTTP_APP_RESET, 32'h0a02_0000, 16'hfffe));
		send_request(make_packet(HTTP_APP_RESET, 32'hc0a8_0001, 16'h8000));
		send_request(make_packet(HTTP_APP_RESET, 32'hffff_ffff, 16'hffff));
		send_request(make_rule(6'd63, 1'b0, 32'hffff_ffff, 32'h0000_0000, 8'd254,
			32'hffff_ffff));
		send_request(make_packet(HTTP_APP_RESET, 32'h0b00_0000, 16'hffff));
		settle_block();
	endtask

	// Register extremes, an unmapped index, exact-host rule ahead of a prefix
	task automatic test_config_extremes();
		write_register(REG_HTTP_APP_TYPE, 32'hffff_ffff);
		write_register(REG_DEFAULT_ACTION, 32'hffff_ffff);
		write_register(REG_UNMAPPED, 32'h0000_0000);
		send_request(make_packet(8'hff, 32'h0c00_0000, 16'h5555));
		send_request(make_packet(HTTP_APP_RESET, 32'h0a01_0000, 16'haaaa));
		send_request(make_packet(8'hff, 32'h0a01_ffff, 16'h0000));
		settle_block();
		write_register(REG_HTTP_APP_TYPE, 32'h0000_0000);
		write_register(REG_DEFAULT_ACTION, 32'h0000_0000);
		send_request(make_packet(8'h00, 32'h0a00_0001, 16'h0f0f));
		send_request(make_packet(8'h00, 32'h0b00_0000, 16'hf0f1));
		send_request(make_rule(6'd1, 1'b1, 32'h0a01_0203, 32'hffff_ffff, 8'd0, 32'h0));
		send_request(make_packet(8'h00, 32'h0a01_0203, 16'h0000));
		send_request(make_packet(8'h00, 32'h0a01_0204, 16'h0000));
		settle_block();
	endtask

	// One random phase under a given register setting and idling mix
	task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] http_word,
			input logic [CFG_DATA_W-1:0] dflt_action, input int send_pct, input int recv_pct);
		int n;
		write_register(REG_HTTP_APP_TYPE, http_word);
		write_register(REG_DEFAULT_ACTION, dflt_action);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (n = 0; n < RANDOM_ITEMS; n++)
			send_request(random_request());
		settle_block();
	endtask

	// Test sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33;
		recv_idle_pct = 78;
		test_reset_state();
		test_rule_order();
		test_config_extremes();
		test_random_traffic({24'($urandom_range(0, 32'hff_ffff)),
			8'($urandom_range(2, 254))}, $urandom(), 33, 78);
		test_random_traffic(32'h0000_0000, 32'h0000_0000, 78, 33);
		test_random_traffic(32'h0000_00ff, 32'hffff_ffff, 0, 0);
		$display("Run covered %0d rule writes and %0d packets: %0d hits, %0d misses, %0d other type",
			rule_writes, pkt_total, pkt_hit, pkt_miss, pkt_other);
		$display("%0d register writes, %0d verdicts checked, %0d mismatches",
			reg_writes, verdicts_seen, error_count);
		if (error_count == 0)
			$display("PASS first_match_ip_prefix_classifier");
		else
			$display("FAIL first_match_ip_prefix_classifier");
		$finish;
	end

endmodule
